@@ hw/rtl/lgi_pkg.sv @@
// Shared constants, types and elaboration-time tables for the modular
// Lagrange interpolation unit. No dependencies; imported by every RTL module.
package lgi_pkg;

  // Block dimensions. MODULUS must be a prime above MAX_POINTS, at least 8192
  // and below 16384 so that a raw 14-bit sample value reduces with a single
  // subtraction.
  localparam int MAX_POINTS = 16;
  localparam int MODULUS    = 10007;

  // Fixed widths of the interface fields.
  localparam int VAL_W  = 14;
  localparam int IDXF_W = 5;
  localparam int PT_W   = 32;
  localparam int CFG_W  = 5;

  // Reset value of the point count register.
  localparam logic [CFG_W-1:0] PCOUNT_RST = CFG_W'(11);

  // Derived widths.
  localparam int RES_W  = $clog2(MODULUS);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int HALF_W = PT_W / 2;
  localparam int OPA_W  = HALF_W;
  localparam int OPB_W  = HALF_W + 1;

  // Barrett reduction constants. The reducer input is a*b+c, which stays
  // below MODULUS * 2^HALF_W, so RED_W bits hold it and the quotient
  // estimate is off by at most two.
  localparam longint RED_MAX = longint'(MODULUS) << HALF_W;
  localparam int     RED_W   = $clog2(RED_MAX);
  localparam longint MU      = (longint'(1) << RED_W) / MODULUS;
  localparam int     MU_W    = $clog2(MU + 1);
  localparam int     R_W     = $clog2(3 * MODULUS);

  localparam logic [RES_W-1:0] MOD_C = RES_W'(MODULUS);

  // Request to the shared modular multiplier: result is (a*b + c) mod MODULUS.
  typedef struct packed {
    logic             issue;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
    logic [OPA_W-1:0] c;
  } mm_req_t;

  // Inverse factorials modulo MODULUS, entry n holds 1/n!.
  typedef logic [MAX_POINTS-1:0][RES_W-1:0] ifact_tab_t;

  function automatic ifact_tab_t build_ifact();
    ifact_tab_t tab;
    longint     f;
    longint     b;
    longint     e;
    longint     r;
    f = 1;
    for (int n = 0; n < MAX_POINTS; n++) begin
      if (n > 0) f = (f * n) % MODULUS;
      b = f;
      e = MODULUS - 2;
      r = 1;
      while (e != 0) begin
        if ((e % 2) == 1) r = (r * b) % MODULUS;
        b = (b * b) % MODULUS;
        e = e >> 1;
      end
      tab[n] = RES_W'(r);
    end
    return tab;
  endfunction

  localparam ifact_tab_t IFACT = build_ifact();

endpackage

@@ hw/rtl/lgi_modmul.sv @@
// Four-stage pipelined modular multiply-add unit, (a*b + c) mod MODULUS.
// Depends on lgi_pkg for widths and Barrett reduction constants.
module lgi_modmul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lgi_pkg::mm_req_t          req_i,
  output logic                      done_o,
  output logic [lgi_pkg::RES_W-1:0] res_o
);
  import lgi_pkg::*;

  localparam logic [MU_W-1:0] MU_C  = MU_W'(MU);
  localparam logic [R_W-1:0]  MOD_R = R_W'(MODULUS);

  logic [3:0]               vld_q;
  logic [OPA_W+OPB_W-1:0]   prod;
  logic [RED_W-1:0]         v_d;
  logic [RED_W-1:0]         v_q;
  logic [RED_W-1:0]         v1_q;
  logic [RED_W+MU_W-1:0]    qfull;
  logic [MU_W-1:0]          q_q;
  logic [MU_W+RES_W-1:0]    qpfull;
  logic [R_W-1:0]           qp_q;
  logic [R_W-1:0]           vlow_q;
  logic [R_W-1:0]           r0;
  logic [R_W-1:0]           r1;
  logic [R_W-1:0]           r2;
  logic [RES_W-1:0]         res_q;

  // Stage 1: product plus addend.
  assign prod = {{OPB_W{1'b0}}, req_i.a} * {{OPA_W{1'b0}}, req_i.b};
  assign v_d  = prod[RED_W-1:0] + RED_W'(req_i.c);

  // Stage 2: quotient estimate. Stage 3: quotient times modulus.
  assign qfull  = {{MU_W{1'b0}}, v_q} * {{RED_W{1'b0}}, MU_C};
  assign qpfull = {{RES_W{1'b0}}, q_q} * {{MU_W{1'b0}}, MOD_C};

  // Stage 4: the true remainder is below three moduli, so the low bits suffice.
  always_comb begin
    r0 = vlow_q - qp_q;
    r1 = (r0 >= MOD_R) ? r0 - MOD_R : r0;
    r2 = (r1 >= MOD_R) ? r1 - MOD_R : r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    q_q    <= qfull[RED_W +: MU_W];
    v1_q   <= v_q;
    qp_q   <= qpfull[R_W-1:0];
    vlow_q <= v1_q[R_W-1:0];
    res_q  <= r2[RES_W-1:0];
  end

  assign done_o = vld_q[3];
  assign res_o  = res_q;

endmodule

@@ hw/rtl/lagrange_interp_mod_prime_unit.sv @@
// Top level of the modular Lagrange interpolation unit: microcode sequencer,
// sample store and result register. Depends on lgi_pkg and lgi_modmul.
//
//   Port group     Direction  Handshake               Contents
//   cfg_*          in         cfg_we_i                point count register
//   in_*           in         in_valid_i / in_stall_o opcode, index, value, point
//   out_*          out        out_valid_o/out_stall_i result value
//
// A load word is written to the sample store when accepted. An evaluate word
// runs a microprogram whose cost is set by the shared multiplier: every
// multiply step issues and then waits through the four pipeline stages, while
// other steps complete in their own cycle.
// Reset clears the sequencer, the output valid flag and sets the point count
// to 11; the sample store is not cleared. The input stalls while an
// evaluation runs; a finished result waits in the output register while new
// words are accepted, and only the final step waits on a stalled output.
module lagrange_interp_mod_prime_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lgi_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [lgi_pkg::IDXF_W-1:0] sample_index_i,
  input  logic [lgi_pkg::VAL_W-1:0]  sample_value_i,
  input  logic [lgi_pkg::PT_W-1:0]   point_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lgi_pkg::VAL_W-1:0]  result_value_o
);
  import lgi_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Sequencer phase.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_EXEC = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  // Microprogram addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_RHI    = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_RLO    = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_PSTORE = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_PMUL   = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_TINIT  = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_TCHK   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_M1     = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_M2     = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_M3     = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_M4     = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_ACC    = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_M5     = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_OUT    = UPC_W'(12);

  typedef enum logic [2:0] {A_PHI, A_X, A_RUN, A_PRE, A_T} asel_e;
  typedef enum logic [2:0] {B_ONE, B_SHIFT, B_DIFF, B_RUN, B_IFI, B_IFK, B_SMP} bsel_e;
  typedef enum logic {C_ZERO, C_PLO} csel_e;
  typedef enum logic [1:0] {D_NONE, D_X, D_RUN, D_T} dest_e;
  typedef enum logic [1:0] {K_HOLD, K_INC, K_DEC, K_LOADK} cnt_e;
  typedef enum logic [1:0] {J_NEXT, J_ALWAYS, J_GE_K, J_ZERO} jmp_e;

  typedef struct packed {
    logic             mul;
    asel_e            asel;
    bsel_e            bsel;
    csel_e            csel;
    dest_e            dest;
    cnt_e             cnt;
    logic             run_one;
    logic             store_pre;
    logic             acc_add;
    logic             finish;
    jmp_e             jmp;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // The microprogram. The value at x is the sum over nodes i of
  //   s(i) * pre(i) * suf(i) * (1/(i-1)!) * (1/(k-i)!) * (-1)^(k-i)
  // where pre(i) is the product of (x-j) for j below i and suf(i) the product
  // for j above i. The prefix products are stored first; the node loop then
  // runs from k down to 1 and builds the suffix product on the way.
  function automatic ucw_t ucode(input logic [UPC_W-1:0] pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      U_RHI: begin
        // Upper half of the point, reduced.
        w.mul = 1'b1; w.asel = A_PHI; w.bsel = B_ONE; w.dest = D_X;
      end
      U_RLO: begin
        // x = (x * 2^16 + lower half) mod p.
        w.mul = 1'b1; w.asel = A_X; w.bsel = B_SHIFT; w.csel = C_PLO; w.dest = D_X;
      end
      U_PSTORE: begin
        w.store_pre = 1'b1; w.jmp = J_GE_K; w.target = U_TINIT;
      end
      U_PMUL: begin
        w.mul = 1'b1; w.asel = A_RUN; w.bsel = B_DIFF; w.dest = D_RUN;
        w.cnt = K_INC; w.jmp = J_ALWAYS; w.target = U_PSTORE;
      end
      U_TINIT: begin
        w.cnt = K_LOADK; w.run_one = 1'b1;
      end
      U_TCHK: begin
        w.jmp = J_ZERO; w.target = U_OUT;
      end
      U_M1: begin
        w.mul = 1'b1; w.asel = A_PRE; w.bsel = B_RUN; w.dest = D_T;
      end
      U_M2: begin
        w.mul = 1'b1; w.asel = A_T; w.bsel = B_IFI; w.dest = D_T;
      end
      U_M3: begin
        w.mul = 1'b1; w.asel = A_T; w.bsel = B_IFK; w.dest = D_T;
      end
      U_M4: begin
        w.mul = 1'b1; w.asel = A_T; w.bsel = B_SMP; w.dest = D_T;
      end
      U_ACC: begin
        w.acc_add = 1'b1;
      end
      U_M5: begin
        w.mul = 1'b1; w.asel = A_RUN; w.bsel = B_DIFF; w.dest = D_RUN;
        w.cnt = K_DEC; w.jmp = J_ALWAYS; w.target = U_TCHK;
      end
      U_OUT: begin
        w.finish = 1'b1;
      end
      default: begin
        w.jmp = J_ALWAYS; w.target = U_OUT;
      end
    endcase
    return w;
  endfunction

  // Control state.
  logic [1:0]       phase_q, phase_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  logic             out_valid_q;
  logic [CFG_W-1:0] cfg_q;

  // Datapath state.
  logic [PT_W-1:0]  pt_q;
  logic [RES_W-1:0] x_q;
  logic [RES_W-1:0] run_q;
  logic [RES_W-1:0] t_q;
  logic [RES_W-1:0] acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] k_q;
  logic [VAL_W-1:0] out_q;
  logic [RES_W-1:0] pre_q    [MAX_POINTS];
  logic [VAL_W-1:0] sample_q [MAX_POINTS];

  ucw_t             cw;
  logic             in_acc;
  logic             load_acc;
  logic             eval_acc;
  logic             idx_ok;
  logic [IDX_W-1:0] widx;
  logic [CNT_W-1:0] k_eff;
  logic             out_busy;
  logic             issue;
  logic             fire;
  logic             take;
  logic [UPC_W-1:0] upc_nxt;
  logic [IDX_W-1:0] cm1;
  logic [CNT_W-1:0] kdiff;
  logic [IDX_W-1:0] kmc;
  logic [RES_W:0]   xe;
  logic [RES_W:0]   ce;
  logic [RES_W:0]   diff_w;
  logic [RES_W-1:0] diff;
  logic [VAL_W-1:0] smp;
  logic [RES_W-1:0] sred;
  logic [RES_W:0]   sum;
  logic             neg;
  logic [RES_W-1:0] acc_nxt;
  mm_req_t          mm_req;
  logic             mm_done;
  logic [RES_W-1:0] mm_res;

  // Input acceptance. A load writes the store at once; an evaluate starts
  // the microprogram. Loads with an index outside 1..MAX_POINTS are dropped.
  assign in_stall_o = (phase_q != PH_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (opcode_i == OP_LOAD);
  assign eval_acc   = in_acc && (opcode_i == OP_EVAL);
  assign idx_ok     = (sample_index_i != '0) && (int'(sample_index_i) <= MAX_POINTS);
  assign widx       = IDX_W'(sample_index_i - IDXF_W'(1));

  // Counts above the store depth saturate.
  assign k_eff = (CNT_W'(cfg_q) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(cfg_q);

  // Node-dependent operands. The counter holds node i, stored entries are
  // indexed by i-1.
  always_comb begin
    cm1   = IDX_W'(cnt_q - CNT_W'(1));
    kdiff = k_q - cnt_q;
    kmc   = kdiff[IDX_W-1:0];
    xe    = {1'b0, x_q};
    ce    = (RES_W+1)'(cnt_q);
    // x - i as a proper residue.
    diff_w = (xe >= ce) ? xe - ce : xe + {1'b0, MOD_C} - ce;
    diff   = diff_w[RES_W-1:0];
    smp    = sample_q[cm1];
    sred   = RES_W'((smp >= VAL_W'(MODULUS)) ? smp - VAL_W'(MODULUS) : smp);
  end

  // Accumulate: the inverse node-difference product carries the sign
  // (-1)^(k-i), so odd distances subtract.
  always_comb begin
    sum = {1'b0, acc_q} + {1'b0, t_q};
    neg = k_q[0] ^ cnt_q[0];
    if (neg) begin
      acc_nxt = (acc_q >= t_q) ? acc_q - t_q
                               : RES_W'({1'b0, acc_q} + {1'b0, MOD_C} - {1'b0, t_q});
    end else begin
      acc_nxt = (sum >= {1'b0, MOD_C}) ? RES_W'(sum - {1'b0, MOD_C}) : sum[RES_W-1:0];
    end
  end

  // Sequencer: a non-multiply step completes in its cycle (the final one waits on
  // a stalled output); a multiply step issues and completes when its result lands.
  always_comb begin
    cw       = ucode(upc_q);
    out_busy = out_valid_q && out_stall_i;
    issue    = (phase_q == PH_EXEC) && cw.mul;
    fire     = ((phase_q == PH_EXEC && !cw.mul) || (phase_q == PH_WAIT && mm_done))
               && !(cw.finish && out_busy);
    unique case (cw.jmp)
      J_NEXT:   take = 1'b0;
      J_ALWAYS: take = 1'b1;
      J_GE_K:   take = (cnt_q >= k_q);
      J_ZERO:   take = (cnt_q == '0);
    endcase
    upc_nxt = take ? cw.target : upc_q + UPC_W'(1);
  end

  always_comb begin
    phase_d = phase_q;
    upc_d   = upc_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (eval_acc) begin
          phase_d = PH_EXEC;
          upc_d   = U_RHI;
        end
      end
      PH_EXEC: begin
        if (issue) begin
          phase_d = PH_WAIT;
        end else if (fire) begin
          upc_d = upc_nxt;
          if (cw.finish) phase_d = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (fire) begin
          phase_d = PH_EXEC;
          upc_d   = upc_nxt;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mm_req.issue = issue;
    unique case (cw.asel)
      A_PHI:   mm_req.a = pt_q[PT_W-1:HALF_W];
      A_X:     mm_req.a = OPA_W'(x_q);
      A_RUN:   mm_req.a = OPA_W'(run_q);
      A_PRE:   mm_req.a = OPA_W'(pre_q[cm1]);
      A_T:     mm_req.a = OPA_W'(t_q);
      default: mm_req.a = '0;
    endcase
    unique case (cw.bsel)
      B_ONE:   mm_req.b = OPB_W'(1);
      B_SHIFT: mm_req.b = {1'b1, {HALF_W{1'b0}}};
      B_DIFF:  mm_req.b = OPB_W'(diff);
      B_RUN:   mm_req.b = OPB_W'(run_q);
      B_IFI:   mm_req.b = OPB_W'(IFACT[cm1]);
      B_IFK:   mm_req.b = OPB_W'(IFACT[kmc]);
      B_SMP:   mm_req.b = OPB_W'(sred);
      default: mm_req.b = '0;
    endcase
    unique case (cw.csel)
      C_ZERO: mm_req.c = '0;
      C_PLO:  mm_req.c = pt_q[HALF_W-1:0];
    endcase
  end

  lgi_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      upc_q       <= U_RHI;
      out_valid_q <= 1'b0;
      cfg_q       <= PCOUNT_RST;
    end else begin
      phase_q <= phase_d;
      upc_q   <= upc_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (fire && cw.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc && idx_ok) sample_q[widx] <= sample_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      pt_q  <= point_i;
      cnt_q <= CNT_W'(1);
      run_q <= RES_W'(1);
      acc_q <= '0;
      k_q   <= k_eff;
    end else if (fire) begin
      unique case (cw.dest)
        D_NONE: begin
        end
        D_X:   x_q   <= mm_res;
        D_RUN: run_q <= mm_res;
        D_T:   t_q   <= mm_res;
      endcase
      if (cw.run_one) run_q <= RES_W'(1);
      unique case (cw.cnt)
        K_HOLD: begin
        end
        K_INC:   cnt_q <= cnt_q + CNT_W'(1);
        K_DEC:   cnt_q <= cnt_q - CNT_W'(1);
        K_LOADK: cnt_q <= k_q;
      endcase
      if (cw.store_pre) pre_q[cm1] <= run_q;
      if (cw.acc_add) acc_q <= acc_nxt;
      if (cw.finish) out_q <= VAL_W'(acc_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q;

`ifndef SYNTHESIS
  // A multiplier result only ever arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (phase_q == PH_WAIT))
    else $error("multiplier result outside wait phase");

  // In the node loop the counter never exceeds the node count.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE && upc_q >= U_TCHK) |-> (cnt_q <= k_q))
    else $error("node counter above node count");

  // A new result appears only after the final microprogram step.
  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(upc_q) == U_OUT))
    else $error("result valid raised outside final step");
`endif

endmodule
